// ===== rtl/mpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_pkg: shared types and constants for the max pooling argmax unit
// Item formats, geometry widths, register indexes and the control bundle
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mpa_pkg;

    localparam int MAX_DIMS      = 4;
    localparam int DIM_W         = 2;
    localparam int DIMC_W        = 3;
    localparam int WIN_W         = 4;
    localparam int EXT_W         = 12;
    localparam int SAMPLE_W      = 16;
    localparam int IDX_W         = 6;
    localparam int LOC_W         = 24;
    localparam int SLAB_AW       = 12;
    localparam int SLAB_DEPTH    = 4096;
    localparam int ELEMS_W       = 16;
    localparam int MAX_WIN_ELEMS = 64;
    localparam int CFG_W         = 48;
    localparam int CFG_IDX_W     = 2;
    localparam int BITCNT_W      = 4;
    localparam int ENTRY_W       = SAMPLE_W + IDX_W;

    typedef logic [DIM_W-1:0]           dim_t;
    typedef logic [DIMC_W-1:0]          dimc_t;
    typedef logic [WIN_W-1:0]           win_t;
    typedef logic [EXT_W-1:0]           ext_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic [LOC_W-1:0]           loc_t;
    typedef logic [SLAB_AW-1:0]         slab_addr_t;
    typedef logic [ELEMS_W-1:0]         elems_t;
    typedef logic [BITCNT_W-1:0]        bitcnt_t;
    typedef logic [ENTRY_W-1:0]         entry_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SIZES  = 2'd2;

    localparam logic [DIMC_W-1:0] DIM_COUNT_RST    = 3'd2;
    localparam logic [15:0]       WINDOW_SIZES_RST = 16'd34;
    localparam logic [CFG_W-1:0]  INPUT_SIZES_RST  = 48'd68736368668;

    localparam logic OP_FORWARD   = 1'b0;
    localparam logic OP_BACKWARD  = 1'b1;
    localparam logic KIND_MAX     = 1'b0;
    localparam logic KIND_SCATTER = 1'b1;

    typedef struct packed {
        logic    operation;
        sample_t sample;
        idx_t    winner_index;
        logic    map_end;
    } in_item_t;

    typedef struct packed {
        logic    kind;
        sample_t result_value;
        idx_t    result_index;
        loc_t    location;
        logic    run_end;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic dec_begin;
        logic dec_load;
        logic dec_step;
        logic dec_store;
        logic dec_bterm;
        logic dec_done;
        logic fwd_commit;
        logic bwd_emit;
        logic bwd_skip;
        dim_t dim;
    } ctrl_cmd_t;

    typedef struct packed {
        logic stale;
        logic operation;
        logic usable;
        logic fwd_emit;
        logic bwd_last;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== rtl/mpa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_div: dual restoring divider, one quotient bit per step
// Divides two extent-wide values by one shared window extent.
// ----------------------------------------------------------------------------
module mpa_div
(
    input  logic          clk,
    input  logic          load,
    input  logic          step,
    input  mpa_pkg::ext_t dividend_a,
    input  mpa_pkg::ext_t dividend_b,
    input  mpa_pkg::win_t divisor,
    output mpa_pkg::ext_t quot_a,
    output mpa_pkg::win_t rem_a,
    output mpa_pkg::ext_t quot_b
);

    mpa_pkg::ext_t quo_a_reg, quo_a_next, quo_b_reg, quo_b_next;
    mpa_pkg::win_t rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [mpa_pkg::WIN_W:0] trial_a, trial_b;
    logic ge_a, ge_b;

    always_comb
    begin
        trial_a = {rem_a_reg, quo_a_reg[mpa_pkg::EXT_W-1]};
        trial_b = {rem_b_reg, quo_b_reg[mpa_pkg::EXT_W-1]};
        ge_a    = trial_a >= {1'b0, divisor};
        ge_b    = trial_b >= {1'b0, divisor};
        rem_a_next = ge_a ? mpa_pkg::win_t'(trial_a - {1'b0, divisor})
                          : mpa_pkg::win_t'(trial_a);
        rem_b_next = ge_b ? mpa_pkg::win_t'(trial_b - {1'b0, divisor})
                          : mpa_pkg::win_t'(trial_b);
        quo_a_next = {quo_a_reg[mpa_pkg::EXT_W-2:0], ge_a};
        quo_b_next = {quo_b_reg[mpa_pkg::EXT_W-2:0], ge_b};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_a_reg <= dividend_a;
            quo_b_reg <= dividend_b;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
        end
        else if (step)
        begin
            quo_a_reg <= quo_a_next;
            quo_b_reg <= quo_b_next;
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
        end
    end

    assign quot_a = quo_a_reg;
    assign rem_a  = rem_a_reg;
    assign quot_b = quo_b_reg;

endmodule

// ===== rtl/mpa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_datapath: geometry, positions, running-max store and output register
// Executes the sequencer's commands; reports status back to it.
// ----------------------------------------------------------------------------
module mpa_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mpa_pkg::ctrl_cmd_t                   cmd,
    output mpa_pkg::ctrl_status_t                status,
    input  logic                                 cfg_write,
    input  logic [mpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mpa_pkg::CFG_W-1:0]            cfg_data,
    input  mpa_pkg::in_item_t                    in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mpa_pkg::out_item_t                   out_item
);

    localparam int N = mpa_pkg::MAX_DIMS;

    // configuration
    mpa_pkg::dimc_t             dim_count_reg;
    logic [15:0]                window_sizes_reg;
    logic [mpa_pkg::CFG_W-1:0]  input_sizes_reg;
    logic                       stale_reg;

    // geometry
    mpa_pkg::win_t   w_reg    [N];
    mpa_pkg::ext_t   n_reg    [N];
    mpa_pkg::ext_t   o_reg    [N];
    mpa_pkg::loc_t   ostr_reg [N];
    mpa_pkg::loc_t   istr_reg [N];
    mpa_pkg::loc_t   bstep_reg[N];
    mpa_pkg::idx_t   lstr_reg [N];
    mpa_pkg::loc_t   ostr_run_reg, istr_run_reg;
    mpa_pkg::idx_t   lstr_run_reg;
    mpa_pkg::elems_t elems_run_reg, elems_reg;
    logic            ok_run_reg, usable_reg;

    // positions
    mpa_pkg::ext_t p_reg    [N];
    mpa_pkg::ext_t q_reg    [N];
    mpa_pkg::win_t r_reg    [N];
    mpa_pkg::loc_t term_reg [N];
    mpa_pkg::ext_t opos_reg [N];
    mpa_pkg::loc_t bterm_reg[N];

    // item and scatter state
    mpa_pkg::in_item_t item_reg;
    mpa_pkg::idx_t     l_reg;
    mpa_pkg::win_t     dig_reg[N];
    mpa_pkg::loc_t     acc_reg[N];
    mpa_pkg::loc_t     addr_reg;

    // store
    mpa_pkg::entry_t mem [mpa_pkg::SLAB_DEPTH];
    mpa_pkg::entry_t rd_reg;

    // output
    logic               out_valid_reg;
    mpa_pkg::out_item_t out_item_reg;

    // combinational
    mpa_pkg::dimc_t  d_eff;
    logic [N-1:0]    dim_on, slab_on;
    mpa_pkg::win_t   w_dec;
    mpa_pkg::ext_t   n_dec;
    mpa_pkg::ext_t   div_q, div_o;
    mpa_pkg::win_t   div_r;
    logic            in_win_ok, first, last;
    mpa_pkg::idx_t   local_idx;
    mpa_pkg::loc_t   oaddr, base;
    mpa_pkg::slab_addr_t slab;
    mpa_pkg::sample_t rd_max;
    mpa_pkg::idx_t    rd_arg;
    logic            upd, fwd_valid, fwd_emit, bwd_last, out_free, out_load;
    logic            bwd_finish;
    mpa_pkg::ext_t   p_adv[N], q_adv[N], opos_adv[N];
    mpa_pkg::win_t   r_adv[N], dig_n[N];
    mpa_pkg::loc_t   term_adv[N], bterm_adv[N], acc_n[N];
    mpa_pkg::loc_t   addr_n;
    mpa_pkg::out_item_t out_n;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg    <= mpa_pkg::DIM_COUNT_RST;
            window_sizes_reg <= mpa_pkg::WINDOW_SIZES_RST;
            input_sizes_reg  <= mpa_pkg::INPUT_SIZES_RST;
            stale_reg        <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    mpa_pkg::CFG_DIM_COUNT:
                        dim_count_reg <= mpa_pkg::dimc_t'(cfg_data);
                    mpa_pkg::CFG_WINDOW_SIZES:
                        window_sizes_reg <= cfg_data[15:0];
                    mpa_pkg::CFG_INPUT_SIZES:
                        input_sizes_reg <= cfg_data;
                    default: ;
                endcase
            end
            // a write during a decode pass leaves the flag set for another pass
            if (cfg_write)
                stale_reg <= 1'b1;
            else if (cmd.dec_begin)
                stale_reg <= 1'b0;
        end
    end

    always_comb
    begin
        if (dim_count_reg == '0)
            d_eff = mpa_pkg::dimc_t'(1);
        else if (dim_count_reg > mpa_pkg::dimc_t'(N))
            d_eff = mpa_pkg::dimc_t'(N);
        else
            d_eff = dim_count_reg;
        for (int i = 0; i < N; i++)
        begin
            dim_on[i]  = mpa_pkg::dimc_t'(i) < d_eff;
            slab_on[i] = mpa_pkg::dimc_t'(i + 1) < d_eff;
        end
    end

    // extents of the dimension under decode; unused dimensions count as 1
    always_comb
    begin
        w_dec = mpa_pkg::win_t'(1);
        n_dec = mpa_pkg::ext_t'(1);
        for (int i = 0; i < N; i++)
        begin
            if (cmd.dim == mpa_pkg::dim_t'(i) && dim_on[i])
            begin
                w_dec = window_sizes_reg[i*mpa_pkg::WIN_W +: mpa_pkg::WIN_W];
                n_dec = input_sizes_reg[i*mpa_pkg::EXT_W +: mpa_pkg::EXT_W];
            end
        end
        if (w_dec == '0)
            w_dec = mpa_pkg::win_t'(1);
    end

    mpa_div u_div
    (
        .clk        (clk),
        .load       (cmd.dec_load),
        .step       (cmd.dec_step),
        .dividend_a (p_reg[cmd.dim]),
        .dividend_b (n_dec),
        .divisor    (w_dec),
        .quot_a     (div_q),
        .rem_a      (div_r),
        .quot_b     (div_o)
    );

    // ---------------- geometry ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.dec_begin)
        begin
            ostr_run_reg  <= mpa_pkg::loc_t'(1);
            istr_run_reg  <= mpa_pkg::loc_t'(1);
            lstr_run_reg  <= mpa_pkg::idx_t'(1);
            elems_run_reg <= mpa_pkg::elems_t'(1);
            ok_run_reg    <= 1'b1;
        end
        if (cmd.dec_store)
        begin
            w_reg[cmd.dim]     <= w_dec;
            n_reg[cmd.dim]     <= n_dec;
            o_reg[cmd.dim]     <= div_o;
            ostr_reg[cmd.dim]  <= ostr_run_reg;
            istr_reg[cmd.dim]  <= istr_run_reg;
            lstr_reg[cmd.dim]  <= lstr_run_reg;
            bstep_reg[cmd.dim] <= mpa_pkg::loc_t'(istr_run_reg * w_dec);
            ostr_run_reg       <= mpa_pkg::loc_t'(ostr_run_reg * div_o);
            istr_run_reg       <= mpa_pkg::loc_t'(istr_run_reg * n_dec);
            lstr_run_reg       <= mpa_pkg::idx_t'(lstr_run_reg * w_dec);
            elems_run_reg      <= mpa_pkg::elems_t'(elems_run_reg * w_dec);
            ok_run_reg         <= ok_run_reg && (div_o != '0);
        end
        if (cmd.dec_done)
            elems_reg <= elems_run_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            usable_reg <= 1'b0;
        else if (cmd.dec_done)
            usable_reg <= ok_run_reg &&
                          (elems_run_reg <= mpa_pkg::elems_t'(mpa_pkg::MAX_WIN_ELEMS));
    end

    // ---------------- forward window view ----------------
    always_comb
    begin
        in_win_ok = 1'b1;
        first     = 1'b1;
        last      = 1'b1;
        local_idx = '0;
        oaddr     = '0;
        base      = '0;
        slab      = '0;
        for (int i = 0; i < N; i++)
        begin
            if (dim_on[i])
            begin
                if (q_reg[i] >= o_reg[i])
                    in_win_ok = 1'b0;
                if (r_reg[i] != '0)
                    first = 1'b0;
                if (r_reg[i] != w_reg[i] - 1'b1)
                    last = 1'b0;
                local_idx = local_idx + mpa_pkg::idx_t'(r_reg[i] * lstr_reg[i]);
                oaddr     = oaddr + term_reg[i];
                base      = base + bterm_reg[i];
            end
            if (slab_on[i])
                slab = slab + mpa_pkg::slab_addr_t'(term_reg[i]);
        end
    end

    assign rd_max    = rd_reg[mpa_pkg::ENTRY_W-1 -: mpa_pkg::SAMPLE_W];
    assign rd_arg    = rd_reg[mpa_pkg::IDX_W-1:0];
    assign upd       = first || (item_reg.sample > rd_max);
    assign fwd_valid = usable_reg && in_win_ok;
    assign fwd_emit  = fwd_valid && last;
    assign bwd_last  = (mpa_pkg::elems_t'(l_reg) + 1'b1) == elems_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // store: read on accept, update on commit
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            rd_reg <= mem[slab];
        if (cmd.fwd_commit && fwd_valid && upd)
            mem[slab] <= {item_reg.sample, local_idx};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= in_item;
    end

    // ---------------- position advance ----------------
    always_comb
    begin
        logic carry_f;
        logic carry_b;
        carry_f = 1'b1;
        carry_b = 1'b1;
        for (int i = 0; i < N; i++)
        begin
            p_adv[i]     = p_reg[i];
            q_adv[i]     = q_reg[i];
            r_adv[i]     = r_reg[i];
            term_adv[i]  = term_reg[i];
            opos_adv[i]  = opos_reg[i];
            bterm_adv[i] = bterm_reg[i];
            if (carry_f && dim_on[i])
            begin
                if (({1'b0, p_reg[i]} + 1'b1) < {1'b0, n_reg[i]})
                begin
                    carry_f  = 1'b0;
                    p_adv[i] = p_reg[i] + 1'b1;
                    if (r_reg[i] == w_reg[i] - 1'b1)
                    begin
                        r_adv[i]    = '0;
                        q_adv[i]    = q_reg[i] + 1'b1;
                        term_adv[i] = term_reg[i] + ostr_reg[i];
                    end
                    else
                        r_adv[i] = r_reg[i] + 1'b1;
                end
                else
                begin
                    p_adv[i]    = '0;
                    q_adv[i]    = '0;
                    r_adv[i]    = '0;
                    term_adv[i] = '0;
                end
            end
            if (carry_b && dim_on[i])
            begin
                if (({1'b0, opos_reg[i]} + 1'b1) < {1'b0, o_reg[i]})
                begin
                    carry_b      = 1'b0;
                    opos_adv[i]  = opos_reg[i] + 1'b1;
                    bterm_adv[i] = bterm_reg[i] + bstep_reg[i];
                end
                else
                begin
                    opos_adv[i]  = '0;
                    bterm_adv[i] = '0;
                end
            end
        end
    end

    assign bwd_finish = cmd.bwd_skip || (cmd.bwd_emit && bwd_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                p_reg[i]     <= '0;
                q_reg[i]     <= '0;
                r_reg[i]     <= '0;
                term_reg[i]  <= '0;
                opos_reg[i]  <= '0;
                bterm_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.dec_store)
            begin
                q_reg[cmd.dim]    <= div_q;
                r_reg[cmd.dim]    <= div_r;
                term_reg[cmd.dim] <= mpa_pkg::loc_t'(ostr_run_reg * div_q);
            end
            if (cmd.dec_bterm)
                bterm_reg[cmd.dim] <= mpa_pkg::loc_t'(bstep_reg[cmd.dim] * opos_reg[cmd.dim]);
            if ((cmd.fwd_commit || bwd_finish) && item_reg.map_end)
            begin
                for (int i = 0; i < N; i++)
                begin
                    p_reg[i]     <= '0;
                    q_reg[i]     <= '0;
                    r_reg[i]     <= '0;
                    term_reg[i]  <= '0;
                    opos_reg[i]  <= '0;
                    bterm_reg[i] <= '0;
                end
            end
            else if (cmd.fwd_commit)
            begin
                p_reg    <= p_adv;
                q_reg    <= q_adv;
                r_reg    <= r_adv;
                term_reg <= term_adv;
            end
            else if (bwd_finish)
            begin
                opos_reg  <= opos_adv;
                bterm_reg <= bterm_adv;
            end
        end
    end

    // ---------------- scatter walk ----------------
    always_comb
    begin
        logic found;
        found  = 1'b0;
        addr_n = addr_reg;
        for (int i = 0; i < N; i++)
        begin
            dig_n[i] = dig_reg[i];
            acc_n[i] = acc_reg[i];
        end
        for (int i = 0; i < N; i++)
        begin
            if (!found && dim_on[i])
            begin
                if (dig_reg[i] != w_reg[i] - 1'b1)
                begin
                    found    = 1'b1;
                    dig_n[i] = dig_reg[i] + 1'b1;
                    addr_n   = acc_reg[i] + istr_reg[i];
                end
                else
                    dig_n[i] = '0;
            end
        end
        found = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            if (!found)
                acc_n[i] = addr_n;
            if (dim_on[i] && dig_reg[i] != w_reg[i] - 1'b1)
                found = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_reg <= '0;
        else if (cmd.accept)
            l_reg <= '0;
        else if (cmd.bwd_emit)
            l_reg <= l_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg <= base;
            for (int i = 0; i < N; i++)
            begin
                dig_reg[i] <= '0;
                acc_reg[i] <= base;
            end
        end
        else if (cmd.bwd_emit)
        begin
            addr_reg <= addr_n;
            dig_reg  <= dig_n;
            acc_reg  <= acc_n;
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        out_load = (cmd.fwd_commit && fwd_emit) || cmd.bwd_emit;
        if (cmd.bwd_emit)
        begin
            out_n.kind         = mpa_pkg::KIND_SCATTER;
            out_n.result_value = (l_reg == item_reg.winner_index) ? item_reg.sample : '0;
            out_n.result_index = l_reg;
            out_n.location     = addr_reg;
            out_n.run_end      = bwd_last;
        end
        else
        begin
            out_n.kind         = mpa_pkg::KIND_MAX;
            out_n.result_value = upd ? item_reg.sample : rd_max;
            out_n.result_index = upd ? local_idx : rd_arg;
            out_n.location     = oaddr;
            out_n.run_end      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_item_reg <= out_n;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign status.stale     = stale_reg;
    assign status.operation = in_item.operation;
    assign status.usable    = usable_reg;
    assign status.fwd_emit  = fwd_emit;
    assign status.bwd_last  = bwd_last;
    assign status.out_free  = out_free;

endmodule

// ===== rtl/mpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_ctrl: sequencer for decode, forward update and backward scatter
// Owns the input handshake and steps the datapath through each request.
// ----------------------------------------------------------------------------
module mpa_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mpa_pkg::ctrl_status_t status,
    output mpa_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DEC_LOAD,
        ST_DEC_DIV,
        ST_DEC_STORE,
        ST_DEC_BTERM,
        ST_FWD,
        ST_BWD
    } state_t;

    state_t           state_reg, state_next;
    mpa_pkg::dim_t    dim_reg, dim_next;
    mpa_pkg::bitcnt_t bit_reg, bit_next;

    always_comb
    begin
        state_next = state_reg;
        dim_next   = dim_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.dim    = dim_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.stale)
                begin
                    cmd.dec_begin = 1'b1;
                    dim_next      = '0;
                    state_next    = ST_DEC_LOAD;
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.accept = 1'b1;
                        state_next = (status.operation == mpa_pkg::OP_BACKWARD)
                                     ? ST_BWD : ST_FWD;
                    end
                end
            end
            ST_DEC_LOAD:
            begin
                cmd.dec_load = 1'b1;
                bit_next     = '0;
                state_next   = ST_DEC_DIV;
            end
            ST_DEC_DIV:
            begin
                cmd.dec_step = 1'b1;
                bit_next     = bit_reg + 1'b1;
                if (bit_reg == mpa_pkg::bitcnt_t'(mpa_pkg::EXT_W - 1))
                    state_next = ST_DEC_STORE;
            end
            ST_DEC_STORE:
            begin
                cmd.dec_store = 1'b1;
                state_next    = ST_DEC_BTERM;
            end
            ST_DEC_BTERM:
            begin
                cmd.dec_bterm = 1'b1;
                if (dim_reg == mpa_pkg::dim_t'(mpa_pkg::MAX_DIMS - 1))
                begin
                    cmd.dec_done = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    dim_next   = dim_reg + 1'b1;
                    state_next = ST_DEC_LOAD;
                end
            end
            ST_FWD:
            begin
                if (!status.fwd_emit || status.out_free)
                begin
                    cmd.fwd_commit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_BWD:
            begin
                if (!status.usable)
                begin
                    cmd.bwd_skip = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.bwd_emit = 1'b1;
                    if (status.bwd_last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dim_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dim_reg   <= dim_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

// ===== rtl/nd_max_pooling_argmax_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nd_max_pooling_argmax_unit: max pooling with argmax, forward and backward
//
// Requests enter on in_valid/in_ready (in_item); results leave on
// out_valid/out_ready (out_item) through a single output register, so a
// new request is taken while the last result still waits.
// Forward request: running-max store read on accept, then compare/update.
// Completing a window yields one result carrying the window maximum, its
// in-window index and the output address.
// Backward request: one scatter result per window element, the last
// flagged with run_end; an unusable geometry yields no results.
// One request is in flight at a time, set by the single-port store and
// the scatter walk.
// After reset, and after any configuration write, the geometry is decoded
// by a shared bit-serial divider, a start step and then a load, division,
// store and offset step for each dimension, during which in_ready stays
// low; a write during a decode pass starts another pass once it ends. Reset
// returns positions to zero and loads the default geometry; store contents
// are undefined until written. When the receiver stalls, the pending result
// holds and the sequencer waits before producing the next one.
// ----------------------------------------------------------------------------
module nd_max_pooling_argmax_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mpa_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mpa_pkg::out_item_t                out_item,
    input  logic                              cfg_write,
    input  logic [mpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mpa_pkg::CFG_W-1:0]         cfg_data
);

    mpa_pkg::ctrl_cmd_t    cmd;
    mpa_pkg::ctrl_status_t status;

    // sequencer: owns in_ready and steps the datapath
    mpa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: geometry, positions, store, output register
    mpa_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== test/nd_max_pooling_argmax_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nd_max_pooling_argmax_unit_tb: self-checking bench for max pooling argmax
// Streams forward elements and backward errors through a randomly idling
// handshake and computes the pooled maxima and scattered errors in a local
// predictor. Every result is checked field by field, in order, over a range
// of window and map geometries, including unusable and empty ones.
// ----------------------------------------------------------------------------
module nd_max_pooling_argmax_unit_tb;

    typedef longint unsigned vec4_t [mpa_pkg::MAX_DIMS];

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    mpa_pkg::in_item_t             in_item = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    mpa_pkg::out_item_t            out_item;
    logic                          cfg_write = 1'b0;
    logic [mpa_pkg::CFG_IDX_W-1:0] cfg_index = mpa_pkg::CFG_DIM_COUNT;
    logic [mpa_pkg::CFG_W-1:0]     cfg_data = '0;

    // Requests waiting for the driver, and results still owed by the block
    mpa_pkg::in_item_t  pending_requests [$];
    mpa_pkg::out_item_t owed_results [$];

    // Predictor copy of the configuration and state
    logic [mpa_pkg::DIMC_W-1:0] geo_dims = mpa_pkg::DIM_COUNT_RST;
    logic [15:0]                geo_windows = mpa_pkg::WINDOW_SIZES_RST;
    logic [mpa_pkg::CFG_W-1:0]  geo_inputs = mpa_pkg::INPUT_SIZES_RST;
    mpa_pkg::sample_t           win_max [mpa_pkg::SLAB_DEPTH];
    mpa_pkg::idx_t              win_arg [mpa_pkg::SLAB_DEPTH];
    vec4_t                      in_pos = '{default: 0};
    vec4_t                      out_pos = '{default: 0};

    int errors = 0;
    int accepted = 0;
    int results_seen = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;

    nd_max_pooling_argmax_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // A quiet stretch with no idling on either side
    function automatic bit calm();
        return accepted >= 150 && accepted < 230;
    endfunction

    // Advance a raster position, dimension zero fastest, wrapping at extents
    function automatic void step_pos(inout vec4_t p, input vec4_t e, input int d);
        for (int i = 0; i < d; i++)
        begin
            p[i]++;
            if (p[i] < e[i])
                return;
            p[i] = 0;
        end
    endfunction

    // Work out the pooled maximum or the scattered errors of one request
    task automatic pool_and_scatter(input mpa_pkg::in_item_t it);
        int                 d;
        vec4_t              w, n, o;
        longint unsigned    elems, q, r, local_idx, lstride, oaddr, ostride, slab;
        longint unsigned    rem, addr, stride;
        bit                 usable, dropped, first, last;
        int                 a;
        mpa_pkg::out_item_t res;
        d = geo_dims;
        if (d < 1)
            d = 1;
        if (d > mpa_pkg::MAX_DIMS)
            d = mpa_pkg::MAX_DIMS;
        elems = 1;
        usable = 1'b1;
        for (int i = 0; i < mpa_pkg::MAX_DIMS; i++)
        begin
            if (i < d)
            begin
                w[i] = (geo_windows >> (4 * i)) & 15;
                if (w[i] == 0)
                    w[i] = 1;
                n[i] = (geo_inputs >> (mpa_pkg::EXT_W * i)) & 12'hFFF;
            end
            else
            begin
                w[i] = 1;
                n[i] = 1;
            end
            o[i] = n[i] / w[i];
            if (o[i] == 0)
                usable = 1'b0;
            elems *= w[i];
        end
        if (elems > mpa_pkg::MAX_WIN_ELEMS)
            usable = 1'b0;

        if (it.operation == mpa_pkg::OP_FORWARD)
        begin
            if (usable)
            begin
                dropped = 1'b0;
                first = 1'b1;
                last = 1'b1;
                local_idx = 0;
                lstride = 1;
                oaddr = 0;
                ostride = 1;
                slab = 0;
                for (int i = 0; i < d; i++)
                begin
                    q = in_pos[i] / w[i];
                    r = in_pos[i] % w[i];
                    if (q >= o[i])
                    begin
                        dropped = 1'b1;
                        break;
                    end
                    if (r != 0)
                        first = 1'b0;
                    if (r != w[i] - 1)
                        last = 1'b0;
                    local_idx += r * lstride;
                    lstride *= w[i];
                    if (i + 1 < d)
                        slab += q * ostride;
                    oaddr += q * ostride;
                    ostride *= o[i];
                end
                if (!dropped)
                begin
                    a = int'(slab % mpa_pkg::SLAB_DEPTH);
                    // strict compare: ties keep the earliest element
                    if (first || it.sample > win_max[a])
                    begin
                        win_max[a] = it.sample;
                        win_arg[a] = mpa_pkg::idx_t'(local_idx);
                    end
                    if (last)
                    begin
                        res.kind = mpa_pkg::KIND_MAX;
                        res.result_value = win_max[a];
                        res.result_index = win_arg[a];
                        res.location = mpa_pkg::loc_t'(oaddr);
                        res.run_end = 1'b1;
                        owed_results = {owed_results, res};
                    end
                end
            end
            step_pos(in_pos, n, d);
        end
        else
        begin
            if (usable)
            begin
                for (longint unsigned l = 0; l < elems; l++)
                begin
                    rem = l;
                    addr = 0;
                    stride = 1;
                    for (int i = 0; i < d; i++)
                    begin
                        r = rem % w[i];
                        rem /= w[i];
                        addr += (out_pos[i] * w[i] + r) * stride;
                        stride *= n[i];
                    end
                    res.kind = mpa_pkg::KIND_SCATTER;
                    res.result_value = (l == it.winner_index)
                                       ? it.sample : mpa_pkg::sample_t'(0);
                    res.result_index = mpa_pkg::idx_t'(l);
                    res.location = mpa_pkg::loc_t'(addr);
                    res.run_end = (l + 1 == elems);
                    owed_results = {owed_results, res};
                end
            end
            step_pos(out_pos, o, d);
        end
        if (it.map_end)
        begin
            in_pos = '{default: 0};
            out_pos = '{default: 0};
        end
    endtask

    // Driver: offer the next request once the current one is taken
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (pending_requests.size() > 0 && (calm() || $urandom_range(99) >= 37))
            begin
                in_item <= pending_requests.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness: random idling plus one long hold-off that lets
    // the block fill up and stall its input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (!stall_done && results_seen >= 40)
            begin
                stall_done <= 1'b1;
                stall_left <= 250;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm() || $urandom_range(99) >= 37;
            end
        end
    end

    // Monitor: predict on every accepted request, check every result
    always @(posedge clk)
    begin
        mpa_pkg::out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pool_and_scatter(in_item);
                accepted <= accepted + 1;
            end
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (owed_results.size() == 0)
                begin
                    $error("unexpected result %p", out_item);
                    errors++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (out_item.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
                        errors++;
                    end
                    if (out_item.result_value !== want.result_value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, out_item.result_value);
                        errors++;
                    end
                    if (out_item.result_index !== want.result_index)
                    begin
                        $error("result_index: expected %0d, got %0d",
                               want.result_index, out_item.result_index);
                        errors++;
                    end
                    if (out_item.location !== want.location)
                    begin
                        $error("location: expected %0d, got %0d",
                               want.location, out_item.location);
                        errors++;
                    end
                    if (out_item.run_end !== want.run_end)
                    begin
                        $error("run_end: expected %0d, got %0d",
                               want.run_end, out_item.run_end);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_request(logic op, mpa_pkg::sample_t s, mpa_pkg::idx_t win,
                                logic last_of_map);
        mpa_pkg::in_item_t it;
        it.operation = op;
        it.sample = s;
        it.winner_index = win;
        it.map_end = last_of_map;
        pending_requests = {pending_requests, it};
    endtask

    // Hold until all requests are taken and all results are in, then allow
    // the datapath to finish a request that owes no result
    task automatic wait_drained();
        while (pending_requests.size() > 0 || in_valid || owed_results.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [mpa_pkg::CFG_IDX_W-1:0] idx,
                             logic [mpa_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            mpa_pkg::CFG_DIM_COUNT:    geo_dims = value[mpa_pkg::DIMC_W-1:0];
            mpa_pkg::CFG_WINDOW_SIZES: geo_windows = value[15:0];
            default:                   geo_inputs = value;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_geometry(logic [2:0] dims, logic [15:0] windows, logic [47:0] sizes);
        write_reg(mpa_pkg::CFG_DIM_COUNT, mpa_pkg::CFG_W'(dims));
        write_reg(mpa_pkg::CFG_WINDOW_SIZES, mpa_pkg::CFG_W'(windows));
        write_reg(mpa_pkg::CFG_INPUT_SIZES, sizes);
    endtask

    // Extremes and near-ties show up often so argmax tie-breaking is exercised
    function automatic mpa_pkg::sample_t pick_sample();
        case ($urandom_range(7))
            0:       return mpa_pkg::sample_t'(16'h8000);
            1:       return mpa_pkg::sample_t'(16'h7FFF);
            2, 3:    return mpa_pkg::sample_t'($urandom_range(3));
            default: return mpa_pkg::sample_t'($urandom);
        endcase
    endfunction

    // Mostly forward streams with random content, some backward errors,
    // rare stray map ends; close the map on the last request
    task automatic random_burst(int count, int elems);
        logic          op;
        mpa_pkg::idx_t win;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(99) < 70) ? mpa_pkg::OP_FORWARD : mpa_pkg::OP_BACKWARD;
            if ($urandom_range(99) < 85)
                win = mpa_pkg::idx_t'($urandom_range(elems - 1));
            else
                win = mpa_pkg::idx_t'($urandom_range(63));
            push_request(op, pick_sample(), win,
                         (i == count - 1) || ($urandom_range(99) < 2));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // One dimension, window of four, map of ten: last two elements dropped
        set_geometry(3'd1, 16'h0004, 48'd10);
        push_request(mpa_pkg::OP_FORWARD, 16'sd5, '0, 1'b0);
        push_request(mpa_pkg::OP_FORWARD, 16'sd5, '0, 1'b0);
        push_request(mpa_pkg::OP_FORWARD, mpa_pkg::sample_t'(16'h8000), '0, 1'b0);
        push_request(mpa_pkg::OP_FORWARD, 16'sd1, '0, 1'b0);
        for (int i = 0; i < 4; i++)
            push_request(mpa_pkg::OP_FORWARD, mpa_pkg::sample_t'(16'h8000), '0, 1'b0);
        push_request(mpa_pkg::OP_FORWARD, mpa_pkg::sample_t'(16'h7FFF), '0, 1'b0);
        push_request(mpa_pkg::OP_FORWARD, 16'sd0, '0, 1'b1);
        push_request(mpa_pkg::OP_BACKWARD, mpa_pkg::sample_t'(16'h7FFF), 6'd0, 1'b0);
        push_request(mpa_pkg::OP_BACKWARD, mpa_pkg::sample_t'(16'h8000), 6'd3, 1'b0);
        push_request(mpa_pkg::OP_BACKWARD, mpa_pkg::sample_t'(16'hFFFF), 6'd63, 1'b1);
        random_burst(40, 4);
        wait_drained();

        // Default geometry: 2x2 windows over 28x28
        set_geometry(3'd2, 16'h0022, 48'd68736368668);
        random_burst(80, 4);
        wait_drained();

        // Four dimensions with a partial window in the last
        set_geometry(3'd4, 16'h2222, {12'd3, 12'd2, 12'd4, 12'd4});
        random_burst(70, 16);
        wait_drained();

        // Largest legal window: 64 elements
        set_geometry(3'd3, 16'h0444, {12'd1, 12'd4, 12'd4, 12'd8});
        random_burst(90, 64);
        wait_drained();

        // Zero dimension count and zero extent read as one; widest map
        set_geometry(3'd0, 16'h0000, {4{12'hFFF}});
        random_burst(50, 1);
        wait_drained();

        // Window far too large: nothing comes out, positions still move
        set_geometry(3'd7, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        random_burst(20, 64);
        wait_drained();

        // Empty output: window wider than the map
        set_geometry(3'd2, 16'h001F, {12'd0, 12'd0, 12'd4, 12'd10});
        random_burst(20, 15);
        wait_drained();

        // Odd window 3x2 over 9x5, trailing row dropped
        set_geometry(3'd2, 16'h0023, {12'd0, 12'd0, 12'd5, 12'd9});
        random_burst(77, 6);
        wait_drained();

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("nd_max_pooling_argmax_unit_tb: PASS");
        else
            $display("nd_max_pooling_argmax_unit_tb: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30_000_000;
        $display("nd_max_pooling_argmax_unit_tb: FAIL");
        $finish;
    end

endmodule
